// ===== rtl/core/cdq_pkg.sv =====
// Shared types, constants and pointer helpers for the circular deque.
package cdq_pkg;

  localparam int DEPTH  = 16;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 32;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } cdq_op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } cdq_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP
  } cdq_state_t;

  typedef struct packed {
    cdq_op_t                   op;
    logic signed [DATA_W-1:0]  value;
  } cdq_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  data;
    cdq_status_t               status;
    logic                      now_empty;
    logic                      now_full;
  } cdq_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture request
    logic exec;     // finish push or refused op
    logic rd;       // issue store read for a pop
    logic pop_fin;  // finish pop with read data
  } cdq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_pop;
    logic refuse;
  } cdq_sts_t;

  function automatic ptr_t next_idx(input ptr_t i);
    return (i == PTR_W'(DEPTH - 1)) ? '0 : ptr_t'(i + 1'b1);
  endfunction

  function automatic ptr_t prev_idx(input ptr_t i);
    return (i == '0) ? PTR_W'(DEPTH - 1) : ptr_t'(i - 1'b1);
  endfunction

endpackage

// ===== rtl/core/circular_deque_core.sv =====
// Circular deque top level: controller plus datapath.
//
// Usage:
//   A request (op, value) is taken at a rising edge where start is high and
//   busy is low. op selects push rear, push front, pop front or pop rear;
//   value is only used by pushes.
//   Each request yields exactly one result on rsp, held for one cycle and
//   marked by done: popped data (-1 on a refused pop, 0 for pushes), a
//   status code and the empty and full flags after the operation.
// Sequencing (no new request is taken until the previous one is finished):
//   Push or refused op: the controller goes from S_IDLE to S_EXEC, which
//   finishes the op; done and the result are then registered.
//   Successful pop: S_EXEC issues the registered store read and S_POP
//   finishes it with the read data; done and the result are then registered.
//   busy is low in the cycle done is shown, so the next request may be
//   taken at the same edge that takes the previous result.
// Reset:
//   rst (sync, active high) empties the queue and clears both pointers;
//   the entry store is not cleared and needs no sweep.
// The receiver cannot stall: a result not taken during its done cycle is gone.
module circular_deque_core import cdq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  cdq_req_t req,
  output logic     done,
  output cdq_rsp_t rsp
);

  cdq_cmd_t cmd;
  cdq_sts_t sts;

  cdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  cdq_dpath u_dpath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .sts  (sts),
    .done (done),
    .rsp  (rsp)
  );

  // an accepted request keeps the block busy for the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // results never come back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // empty and full cannot both be reported
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.now_empty && rsp.now_full))
    else $error("result reports empty and full together");

  // a push refused for fullness leaves the queue full
  a_full_refuse: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_FULL) |-> rsp.now_full)
    else $error("full refusal without full flag");

endmodule

// ===== rtl/core/cdq_ram.sv =====
// Generic single-port RAM with registered read.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/core/cdq_ctrl.sv =====
// Sequencing state machine for the circular deque.
module cdq_ctrl import cdq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  cdq_sts_t sts,
  output cdq_cmd_t cmd
);

  cdq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_pop && !sts.refuse) begin
          cmd.rd     = 1'b1;
          state_next = S_POP;
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        cmd.pop_fin = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/cdq_dpath.sv =====
// Pointers, empty flag, entry store and result register of the deque.
module cdq_dpath import cdq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cdq_req_t req,
  input  cdq_cmd_t cmd,
  output cdq_sts_t sts,
  output logic     done,
  output cdq_rsp_t rsp
);

  cdq_req_t req_q;
  ptr_t     head, head_next;
  ptr_t     tail, tail_next;
  logic     empty_q, empty_next;
  logic     full;
  cdq_rsp_t rsp_next;
  logic     we;
  ptr_t     waddr;
  ptr_t     ram_addr;
  logic [DATA_W-1:0] rdata;
  logic     is_pop;

  assign is_pop = (req_q.op == OP_POP_FRONT) || (req_q.op == OP_POP_REAR);
  assign full   = !empty_q && (next_idx(tail) == head);

  assign sts.is_pop = is_pop;
  assign sts.refuse = is_pop ? empty_q : full;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    empty_next = empty_q;
    we         = 1'b0;
    waddr      = '0;
    rsp_next   = '0;
    rsp_next.status = ST_DONE;

    if (cmd.exec) begin
      if (is_pop) begin
        // pop from empty queue
        rsp_next.status = ST_EMPTY;
        rsp_next.data   = '1;
      end else if (full) begin
        rsp_next.status = ST_FULL;
      end else begin
        we = 1'b1;
        if (empty_q) begin
          head_next  = '0;
          tail_next  = '0;
          empty_next = 1'b0;
          waddr      = '0;
        end else if (req_q.op == OP_PUSH_REAR) begin
          tail_next = next_idx(tail);
          waddr     = tail_next;
        end else begin
          head_next = prev_idx(head);
          waddr     = head_next;
        end
      end
    end

    if (cmd.pop_fin) begin
      rsp_next.data = rdata;
      if (head == tail) begin
        // last entry leaves
        head_next  = '0;
        tail_next  = '0;
        empty_next = 1'b1;
      end else if (req_q.op == OP_POP_FRONT) begin
        head_next = next_idx(head);
      end else begin
        tail_next = prev_idx(tail);
      end
    end

    rsp_next.now_empty = empty_next;
    rsp_next.now_full  = !empty_next && (next_idx(tail_next) == head_next);
  end

  assign ram_addr = we ? waddr : ((req_q.op == OP_POP_FRONT) ? head : tail);

  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .re    (cmd.rd),
    .addr  (ram_addr),
    .wdata (req_q.value),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      empty_q <= 1'b1;
      done    <= 1'b0;
    end else begin
      head    <= head_next;
      tail    <= tail_next;
      empty_q <= empty_next;
      done    <= cmd.exec || cmd.pop_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (cmd.exec || cmd.pop_fin) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== test/tb_circular_deque_core.sv =====
// Testbench for circular_deque_core: directed and random deque traffic against a built-in model.
module tb_circular_deque_core import cdq_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Longest legal stretch without a request or result taken is an idle burst
  // plus a pop in flight; the limit leaves a wide margin on that.
  localparam int QUIET_LIMIT = 400;
  localparam int MAX_SHOWN   = 10;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  cdq_req_t req = '0;
  logic     done;
  cdq_rsp_t rsp;

  circular_deque_core DUT (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Deque model: own copy of the entries, front/rear indexes and fill level.
  // Fill level replaces the empty flag; full is simply level == DEPTH.
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] model_mem [DEPTH];
  int model_front;
  int model_rear;
  int model_level;

  cdq_rsp_t pending_rsp_q[$];   // expected results, oldest first

  int err_cnt;
  int n_req;
  int n_push;
  int n_pop;
  int n_refused_full;
  int n_refused_empty;
  int n_reached_full;

  function automatic int wrap_up(input int i);
    return (i + 1) % DEPTH;
  endfunction

  function automatic int wrap_down(input int i);
    return (i + DEPTH - 1) % DEPTH;
  endfunction

  // Applies one request to the model and returns the result it must produce.
  function automatic cdq_rsp_t deque_apply(input cdq_req_t r);
    cdq_rsp_t o;
    o.data   = '0;
    o.status = ST_DONE;
    if (r.op == OP_PUSH_REAR || r.op == OP_PUSH_FRONT) begin
      if (model_level == DEPTH) begin
        o.status = ST_FULL;
      end else if (model_level == 0) begin
        // first entry always lands in slot 0, whichever end it came in by
        model_front  = 0;
        model_rear   = 0;
        model_mem[0] = r.value;
        model_level  = 1;
      end else if (r.op == OP_PUSH_REAR) begin
        model_rear = wrap_up(model_rear);
        model_mem[model_rear] = r.value;
        model_level++;
      end else begin
        model_front = wrap_down(model_front);
        model_mem[model_front] = r.value;
        model_level++;
      end
    end else begin
      if (model_level == 0) begin
        o.status = ST_EMPTY;
        o.data   = -1;
      end else begin
        o.data = (r.op == OP_POP_FRONT) ? model_mem[model_front] : model_mem[model_rear];
        if (model_level == 1) begin
          // last entry gone: both indexes go back to slot 0
          model_front = 0;
          model_rear  = 0;
        end else if (r.op == OP_POP_FRONT) begin
          model_front = wrap_up(model_front);
        end else begin
          model_rear = wrap_down(model_rear);
        end
        model_level--;
      end
    end
    o.now_empty = (model_level == 0);
    o.now_full  = (model_level == DEPTH);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Called right after a rising edge; returns right after the
  // edge that took the request, with start still high so a following request
  // goes out back to back.
  // ---------------------------------------------------------------------------
  task automatic send_request(input cdq_req_t r);
    cdq_rsp_t want;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    want = deque_apply(r);
    pending_rsp_q.push_back(want);
    n_req++;
    if (r.op == OP_PUSH_REAR || r.op == OP_PUSH_FRONT) n_push++;
    else n_pop++;
    if (want.status == ST_FULL) n_refused_full++;
    if (want.status == ST_EMPTY) n_refused_empty++;
    if (want.status == ST_DONE && want.now_full) n_reached_full++;
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Sender holds off until every result in flight has come back.
  task automatic drain_pending();
    if (pending_rsp_q.size() != 0) begin
      start <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clk);
    end
  endtask

  function automatic cdq_req_t make_req(input cdq_op_t op, input logic [DATA_W-1:0] v);
    cdq_req_t r;
    r.op    = op;
    r.value = v;
    return r;
  endfunction

  // Word mix weighted toward the sign and range extremes.
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic cdq_op_t pick_push();
    return ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_REAR;
  endfunction

  function automatic cdq_op_t pick_pop();
    return ($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_REAR;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: done marks a one-cycle result, sampled at the edge that
  // closes that cycle. Compared field by field with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cdq_rsp_t want;
    if (!rst && done) begin
      if (pending_rsp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_SHOWN)
          $display("%0t: result with no request outstanding: data=%0d status=%s e=%b f=%b",
                   $realtime, rsp.data, rsp.status.name(), rsp.now_empty, rsp.now_full);
      end else begin
        want = pending_rsp_q[0];
        pending_rsp_q.delete(0);
        if (rsp.data !== want.data || rsp.status !== want.status ||
            rsp.now_empty !== want.now_empty || rsp.now_full !== want.now_full) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN)
            $display({"%0t: mismatch: exp data=%0d status=%s e=%b f=%b,",
                      " got data=%0d status=%s e=%b f=%b"},
                     $realtime, want.data, want.status.name(), want.now_empty, want.now_full,
                     rsp.data, rsp.status.name(), rsp.now_empty, rsp.now_full);
        end
      end
    end
  end

  // Watchdog: ends the run if neither side moves anything for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no request or result for %0d cycles", QUIET_LIMIT);
    $display("tb_circular_deque_core: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Refused pops on the empty queue, extremes of the word, push into empty
  // from either end, pop of the last entry from either end.
  task automatic test_empty_edges();
    send_request(make_req(OP_POP_FRONT, 32'h1234_5678));
    send_request(make_req(OP_POP_REAR, 32'hFFFF_FFFF));
    send_request(make_req(OP_PUSH_REAR, 32'h7FFF_FFFF));
    send_request(make_req(OP_PUSH_FRONT, 32'h8000_0000));
    send_request(make_req(OP_POP_REAR, 32'h0));
    send_request(make_req(OP_POP_FRONT, 32'h0));      // takes the last entry
    send_request(make_req(OP_PUSH_FRONT, 32'hFFFF_FFFF));
    send_request(make_req(OP_POP_REAR, 32'h0));       // last entry from the rear
    send_request(make_req(OP_PUSH_REAR, 32'h0));
    send_request(make_req(OP_PUSH_REAR, 32'h5555_5555));
    send_request(make_req(OP_PUSH_FRONT, 32'hAAAA_AAAA));
    send_request(make_req(OP_POP_FRONT, 32'h0));
    send_request(make_req(OP_POP_FRONT, 32'h0));
    send_request(make_req(OP_POP_FRONT, 32'h0));
    send_request(make_req(OP_POP_REAR, 32'h0));       // refused again
    idle_cycles(1);
  endtask

  // Fill to DEPTH from both ends (the front index wraps), refused pushes at full,
  // a pause until everything is back, then drain from both ends to empty.
  task automatic test_fill_and_drain();
    for (int i = 0; i < DEPTH; i++)
      send_request(make_req((i % 2) ? OP_PUSH_FRONT : OP_PUSH_REAR, pick_word()));
    send_request(make_req(OP_PUSH_REAR, $urandom));
    send_request(make_req(OP_PUSH_FRONT, $urandom));
    drain_pending();
    for (int i = 0; i < DEPTH; i++)
      send_request(make_req((i % 3 == 0) ? OP_POP_REAR : OP_POP_FRONT, $urandom));
    send_request(make_req(OP_POP_FRONT, $urandom));
    idle_cycles(1);
  endtask

  // Random traffic in chunks; each chunk leans toward pushing, popping or
  // neither so the queue sweeps between empty and full. Idle density also
  // varies per chunk, with some chunks running back to back.
  task automatic test_random_traffic(input int n_chunks);
    int push_pct;
    int idle_pct;
    int chunk_len;
    cdq_op_t op;
    for (int c = 0; c < n_chunks; c++) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
      chunk_len = $urandom_range(20, 40);
      for (int k = 0; k < chunk_len; k++) begin
        op = ($urandom_range(0, 99) < push_pct) ? pick_push() : pick_pop();
        send_request(make_req(op, pick_word()));
        if ($urandom_range(0, 99) < idle_pct)
          idle_cycles($urandom_range(1, 16));
      end
      if ($urandom_range(0, 3) == 0)
        drain_pending();
    end
  endtask

  // Closing stretch with no idling at all.
  task automatic test_back_to_back(input int n);
    for (int k = 0; k < n; k++)
      send_request(make_req(($urandom_range(0, 1) != 0) ? pick_push() : pick_pop(), pick_word()));
    idle_cycles(1);
  endtask

  initial begin
    err_cnt         = 0;
    n_req           = 0;
    n_push          = 0;
    n_pop           = 0;
    n_refused_full  = 0;
    n_refused_empty = 0;
    n_reached_full  = 0;
    model_front     = 0;
    model_rear      = 0;
    model_level     = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_edges();
    test_fill_and_drain();
    test_random_traffic(12);
    test_back_to_back(60);

    // wait out everything in flight, then keep watching for stray results
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (pending_rsp_q.size() != 0) begin
      err_cnt++;
      $display("%0d expected results never arrived", pending_rsp_q.size());
    end

    $display("covered %0d requests: %0d pushes, %0d pops, queue filled %0d times",
             n_req, n_push, n_pop, n_reached_full);
    $display("refusals seen: %0d push into full, %0d pop from empty; %0d mismatches",
             n_refused_full, n_refused_empty, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_circular_deque_core: clean");
    end else begin
      $display("tb_circular_deque_core: errors");
    end
    $finish;
  end

endmodule

// ===== circular_deque_core.f =====
rtl/core/cdq_pkg.sv
rtl/core/cdq_ram.sv
rtl/core/cdq_ctrl.sv
rtl/core/cdq_dpath.sv
rtl/core/circular_deque_core.sv
test/tb_circular_deque_core.sv
